// ===== hw/rtl/ael_pkg.sv =====
package ael_pkg;

   localparam int NODE_W            = 4;
   localparam int COUNT_W           = 5;
   localparam int STATUS_W          = 2;
   localparam int COMPARE_W         = 8;
   localparam int MAX_NODES_DEFAULT = 16;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

   localparam logic [STATUS_W-1:0] STATUS_LOCKED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_LOCK
   } state_type;

endpackage

// ===== hw/rtl/ael_ram.sv =====
module ael_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/acyclic_edge_locker_core.sv =====
// Cycle-free edge locker over a directed graph of up to MAX_NODES nodes.
//
// Request channel: start with req_from_node (winner) and req_to_node (loser).
// A request is taken at a rising edge where start is high and busy is low.
// Response channel: rsp_valid is high for exactly one cycle with rsp_status:
// locked, rejected because the edge would close a cycle, or rejected because a
// node index is at or above node_count. The receiver cannot stall; every
// response is taken in the cycle it is shown.
// Configuration: csr_wr_en with csr_wr_data writes node_count (reset 16).
//
// Out-of-range and self edges answer in the cycle after the request, with
// busy never raised. Otherwise the block walks the set of nodes reachable from
// the loser, reading one adjacency row per cycle from the edge RAM through its
// single read port. A new request can be taken in the cycle its response
// appears.
// Reset clears all row valid bits, so the graph starts empty without a
// clearing pass, and node_count returns to 16.
module acyclic_edge_locker_core
   import ael_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [NODE_W-1:0]   req_from_node,
   input  logic [NODE_W-1:0]   req_to_node,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam logic [COMPARE_W-1:0] MAX_COUNT = COMPARE_W'(MAX_NODES);

   typedef logic [MAX_NODES-1:0] row_type;

   localparam row_type ROW_ONE = row_type'(1);

   state_type           state_ff, state_in;
   row_type             reach_ff, reach_in;
   row_type             done_ff, done_in;
   row_type             row_valid_ff, row_valid_in;
   logic                inflight_ff, inflight_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [NODE_W-1:0]   from_ff, from_in;
   logic [NODE_W-1:0]   to_ff, to_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  node_count_ff, node_count_in;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   row_type              rd_data;
   logic                 wr_en;
   row_type              wr_data;
   row_type              row_data;
   row_type              reach_eff;
   row_type              pending;
   logic [IDX_W-1:0]     pick_idx;
   logic [IDX_W-1:0]     from_idx;
   logic [NODE_W+IDX_W-1:0] from_ext;
   logic [COMPARE_W-1:0] count_raw;
   logic [COMPARE_W-1:0] count_eff;
   logic                 out_of_range;

   ael_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (from_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign from_ext = {{IDX_W{1'b0}}, from_ff};
   assign from_idx = from_ext[IDX_W-1:0];

   // Rows never written read as empty.
   assign row_data  = rd_valid_ff ? rd_data : '0;
   assign reach_eff = reach_ff | (inflight_ff ? row_data : '0);
   assign pending   = reach_eff & ~done_ff;
   assign wr_data   = row_data | (ROW_ONE << to_ff);

   assign count_raw    = {{(COMPARE_W-COUNT_W){1'b0}}, node_count_ff};
   assign count_eff    = (count_raw > MAX_COUNT) ? MAX_COUNT : count_raw;
   assign out_of_range =
      ({{(COMPARE_W-NODE_W){1'b0}}, req_from_node} >= count_eff) ||
      ({{(COMPARE_W-NODE_W){1'b0}}, req_to_node} >= count_eff);

   always_comb begin
      pick_idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (pending[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_valid_ff  <= '0;
         inflight_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         inflight_ff   <= inflight_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
      reach_ff      <= reach_in;
      done_ff       <= done_in;
      rd_valid_ff   <= rd_valid_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      reach_in      = reach_ff;
      done_in       = done_ff;
      row_valid_in  = row_valid_ff;
      inflight_in   = 1'b0;
      rd_valid_in   = rd_valid_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      rd_en         = 1'b0;
      rd_addr       = from_idx;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               from_in = req_from_node;
               to_in   = req_to_node;
               if (out_of_range) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_RANGE;
               end else if (req_from_node == req_to_node) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_CYCLE;
               end else begin
                  reach_in = ROW_ONE << req_to_node;
                  done_in  = '0;
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (|(reach_eff & (ROW_ONE << from_ff))) begin
               // The loser already reaches the winner.
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_CYCLE;
               state_in      = S_IDLE;
            end else if (|pending) begin
               rd_en       = 1'b1;
               rd_addr     = pick_idx;
               rd_valid_in = row_valid_ff[pick_idx];
               reach_in    = reach_eff;
               done_in     = done_ff | (ROW_ONE << pick_idx);
               inflight_in = 1'b1;
            end else begin
               // Search exhausted: fetch the winner's row for the update.
               rd_en       = 1'b1;
               rd_addr     = from_idx;
               rd_valid_in = row_valid_ff[from_idx];
               state_in    = S_LOCK;
            end
         end
         S_LOCK: begin
            wr_en                  = 1'b1;
            row_valid_in[from_idx] = 1'b1;
            rsp_valid_in           = 1'b1;
            rsp_status_in          = STATUS_LOCKED;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hw/rtl/ael_checker.sv =====
module ael_checker
   import ael_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [NODE_W-1:0]   req_from_node,
   input logic [NODE_W-1:0]   req_to_node,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                csr_wr_en,
   input logic [COUNT_W-1:0]  csr_wr_data
);

   a_idle_after_reset: assert property (
      @(posedge clock) reset |=> (!busy && !rsp_valid)
   ) else $error("block not idle after reset");

   a_status_legal: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_LOCKED || rsp_status == STATUS_CYCLE ||
                     rsp_status == STATUS_RANGE)
   ) else $error("illegal response status");

   a_self_edge: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy && req_from_node == req_to_node) |=>
         (rsp_valid && !busy &&
          (rsp_status == STATUS_CYCLE || rsp_status == STATUS_RANGE))
   ) else $error("self edge not rejected in one cycle");

   a_busy_ends_with_response: assert property (
      @(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid
   ) else $error("busy dropped without a response");

   a_no_response_while_searching: assert property (
      @(posedge clock) disable iff (reset)
      (busy && $past(busy) && !$past(reset)) |-> !rsp_valid
   ) else $error("response while a request is still in progress");

endmodule

bind acyclic_edge_locker_core ael_checker u_ael_checker (.*);
